// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the list store checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg
// Sizes, field layout, operation and status codes for the list store.
// ----------------------------------------------------------------------------
package pls_pkg;

    // Storage geometry
    localparam int DEPTH     = 64;
    localparam int ELEM_BITS = 32;
    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    // Fixed field widths
    localparam int KIND_BITS   = 3;
    localparam int POS_BITS    = 7;
    localparam int STATUS_BITS = 2;
    localparam int CMP_BITS    = (POS_BITS > CNT_BITS) ? POS_BITS : CNT_BITS;

    // Read gather tree: cells per first-level group
    localparam int GROUP   = 8;
    localparam int NGROUPS = (DEPTH + GROUP - 1) / GROUP;

    // Input stream layout: tdata = {new_value, position}, tuser = kind
    localparam int IN_POS_LSB    = 0;
    localparam int IN_VAL_LSB    = IN_POS_LSB + POS_BITS;
    localparam int IN_DATA_BITS  = ((POS_BITS + ELEM_BITS + 7) / 8) * 8;
    localparam int IN_USED_BITS  = POS_BITS + ELEM_BITS;

    // Output stream layout: tdata = {count_after, read_value, status}
    localparam int OUT_ST_LSB    = 0;
    localparam int OUT_RD_LSB    = OUT_ST_LSB + STATUS_BITS;
    localparam int OUT_CNT_LSB   = OUT_RD_LSB + ELEM_BITS;
    localparam int OUT_USED_BITS = STATUS_BITS + ELEM_BITS + CNT_BITS;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_APPEND = 3'd0,
        KIND_PUSH   = 3'd1,
        KIND_INSERT = 3'd2,
        KIND_SET    = 3'd3,
        KIND_GET    = 3'd4,
        KIND_POP    = 3'd5,
        KIND_REMOVE = 3'd6,
        KIND_NONE   = 3'd7
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_WRITE  = 2'd2,
        CELL_REMOVE = 2'd3
    } cell_op_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_RESULT = 1'b1
    } state_t;

    // Command broadcast to every cell of the row
    typedef struct packed {
        cell_op_t            op;
        logic [IDX_BITS-1:0] pos;
        logic [IDX_BITS-1:0] last;
        logic                rd_en;
    } cell_ctrl_t;

endpackage

// ===== design/pls_cell.sv =====
// ----------------------------------------------------------------------------
// pls_cell
// One list slot: holds an element, takes a neighbor's element on a shift.
// ----------------------------------------------------------------------------
module pls_cell
(
    input  logic                          clk,
    input  logic                          upd,
    input  pls_pkg::cell_ctrl_t           ctrl,
    input  logic [pls_pkg::IDX_BITS-1:0]  index,
    input  logic [pls_pkg::ELEM_BITS-1:0] new_value,
    input  logic [pls_pkg::ELEM_BITS-1:0] left_data,
    input  logic [pls_pkg::ELEM_BITS-1:0] right_data,
    output logic [pls_pkg::ELEM_BITS-1:0] data,
    output logic [pls_pkg::ELEM_BITS-1:0] rd_data
);

    logic [pls_pkg::ELEM_BITS-1:0] data_reg;
    logic [pls_pkg::ELEM_BITS-1:0] data_next;

    // Pick the slot's next element from the broadcast command
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            pls_pkg::CELL_INSERT:
            begin
                if (index == ctrl.pos)
                begin
                    data_next = new_value;
                end
                else if ((index > ctrl.pos) && (index <= ctrl.last))
                begin
                    data_next = left_data;
                end
            end
            pls_pkg::CELL_WRITE:
            begin
                if (index == ctrl.pos)
                begin
                    data_next = new_value;
                end
            end
            pls_pkg::CELL_REMOVE:
            begin
                if (index == ctrl.last)
                begin
                    data_next = '0;
                end
                else if ((index >= ctrl.pos) && (index < ctrl.last))
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Hold the element; advance only on an accepted transfer
    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            data_reg <= data_next;
        end
    end

    assign data    = data_reg;
    assign rd_data = (ctrl.rd_en && (index == ctrl.pos)) ? data_reg : '0;

endmodule

// ===== design/pls_gather.sv =====
// ----------------------------------------------------------------------------
// pls_gather
// Registered OR tree that collects the one selected cell's element.
// ----------------------------------------------------------------------------
module pls_gather
(
    input  logic                          clk,
    input  logic                          load,
    input  logic [pls_pkg::ELEM_BITS-1:0] cell_rd [pls_pkg::DEPTH],
    output logic [pls_pkg::ELEM_BITS-1:0] word
);

    logic [pls_pkg::ELEM_BITS-1:0] group_reg  [pls_pkg::NGROUPS];
    logic [pls_pkg::ELEM_BITS-1:0] group_next [pls_pkg::NGROUPS];

    // First level: fold each group of cells
    always_comb
    begin
        for (int g = 0; g < pls_pkg::NGROUPS; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < pls_pkg::GROUP; k++)
            begin
                if (g * pls_pkg::GROUP + k < pls_pkg::DEPTH)
                begin
                    group_next[g] = group_next[g] | cell_rd[g * pls_pkg::GROUP + k];
                end
            end
        end
    end

    // Capture the group results at the accepting transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int g = 0; g < pls_pkg::NGROUPS; g++)
            begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    // Second level: fold the group registers
    always_comb
    begin
        word = '0;
        for (int g = 0; g < pls_pkg::NGROUPS; g++)
        begin
            word = word | group_reg[g];
        end
    end

endmodule

// ===== design/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of fixed-width elements with positional insert and remove.
// ----------------------------------------------------------------------------
// Usage:
//   The s_* channel carries one list operation per transfer: the kind in
//   s_tuser, position and new element in s_tdata. The m_* channel returns
//   exactly one result per operation: status, element read or removed, and
//   the element count after the operation.
//   The list lives in a row of cells; an insert or remove moves every later
//   cell by one slot in the same cycle, so no operation iterates.
//   Timing: the operation is applied at the accepting edge; its result is
//   held in the gather-tree and status registers, then moves to the output
//   register, which raises m_tvalid. s_tready stays low until that move, so
//   a new operation is not taken before the last one's result has moved.
//   Stall: while m_tvalid is high and m_tready low, the result holds; a
//   second result waits in the block, and s_tready stays low until the
//   output register frees up.
//   Reset: rst_n clears the count (empty list), the control state and
//   m_tvalid. Element storage is not cleared; unwritten slots are never
//   visible.
// ----------------------------------------------------------------------------
module positional_list_store
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [6:0] position, [38:7] new_value, upper bits zero
    input  logic [pls_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // [2:0] kind
    input  logic [pls_pkg::KIND_BITS-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] status, [33:2] read_value, [40:34] count_after, upper bits zero
    output logic [pls_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    pls_pkg::state_t                   state_reg;
    pls_pkg::state_t                   state_next;
    logic [pls_pkg::CNT_BITS-1:0]      count_reg;
    logic [pls_pkg::CNT_BITS-1:0]      count_next;
    pls_pkg::status_t                  status_reg;
    pls_pkg::status_t                  status_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [pls_pkg::OUT_DATA_BITS-1:0] out_data_reg;
    logic [pls_pkg::OUT_DATA_BITS-1:0] out_data_next;

    logic                              accept;
    logic                              load_out;
    pls_pkg::kind_t                    kind;
    logic [pls_pkg::POS_BITS-1:0]      position;
    logic [pls_pkg::ELEM_BITS-1:0]     new_value;
    logic [pls_pkg::CMP_BITS-1:0]      pos_w;
    logic [pls_pkg::CMP_BITS-1:0]      cnt_w;
    logic                              full;
    logic                              empty;
    pls_pkg::cell_ctrl_t               ctrl;

    logic [pls_pkg::ELEM_BITS-1:0]     cell_data [pls_pkg::DEPTH];
    logic [pls_pkg::ELEM_BITS-1:0]     cell_rd   [pls_pkg::DEPTH];
    logic [pls_pkg::ELEM_BITS-1:0]     gathered;

    // Unpack the input transfer
    assign kind      = pls_pkg::kind_t'(s_tuser);
    assign position  = s_tdata[pls_pkg::IN_POS_LSB +: pls_pkg::POS_BITS];
    assign new_value = s_tdata[pls_pkg::IN_VAL_LSB +: pls_pkg::ELEM_BITS];
    assign pos_w     = pls_pkg::CMP_BITS'(position);
    assign cnt_w     = pls_pkg::CMP_BITS'(count_reg);
    assign full      = (count_reg == pls_pkg::CNT_BITS'(pls_pkg::DEPTH));
    assign empty     = (count_reg == '0);

    // Decode the operation into a cell command, status and new count
    always_comb
    begin
        ctrl        = '{op: pls_pkg::CELL_HOLD, pos: '0, last: '0, rd_en: 1'b0};
        status_next = pls_pkg::ST_OK;
        count_next  = count_reg;
        case (kind)
            pls_pkg::KIND_APPEND,
            pls_pkg::KIND_PUSH,
            pls_pkg::KIND_INSERT:
            begin
                if ((kind == pls_pkg::KIND_INSERT) && (pos_w > cnt_w))
                begin
                    status_next = pls_pkg::ST_BADPOS;
                end
                else if (full)
                begin
                    status_next = pls_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.op    = pls_pkg::CELL_INSERT;
                    ctrl.last  = pls_pkg::IDX_BITS'(count_reg);
                    count_next = count_reg + 1'b1;
                    if (kind == pls_pkg::KIND_APPEND)
                    begin
                        ctrl.pos = pls_pkg::IDX_BITS'(count_reg);
                    end
                    else if (kind == pls_pkg::KIND_INSERT)
                    begin
                        ctrl.pos = pls_pkg::IDX_BITS'(position);
                    end
                end
            end
            pls_pkg::KIND_SET,
            pls_pkg::KIND_GET:
            begin
                if (pos_w >= cnt_w)
                begin
                    status_next = pls_pkg::ST_BADPOS;
                end
                else
                begin
                    ctrl.pos = pls_pkg::IDX_BITS'(position);
                    if (kind == pls_pkg::KIND_SET)
                    begin
                        ctrl.op = pls_pkg::CELL_WRITE;
                    end
                    else
                    begin
                        ctrl.rd_en = 1'b1;
                    end
                end
            end
            pls_pkg::KIND_POP:
            begin
                if (empty)
                begin
                    status_next = pls_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.op    = pls_pkg::CELL_REMOVE;
                    ctrl.pos   = pls_pkg::IDX_BITS'(count_reg - 1'b1);
                    ctrl.last  = pls_pkg::IDX_BITS'(count_reg - 1'b1);
                    ctrl.rd_en = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            pls_pkg::KIND_REMOVE:
            begin
                if (empty)
                begin
                    status_next = pls_pkg::ST_EMPTY;
                end
                else if (pos_w >= cnt_w)
                begin
                    status_next = pls_pkg::ST_BADPOS;
                end
                else
                begin
                    ctrl.op    = pls_pkg::CELL_REMOVE;
                    ctrl.pos   = pls_pkg::IDX_BITS'(position);
                    ctrl.last  = pls_pkg::IDX_BITS'(count_reg - 1'b1);
                    ctrl.rd_en = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = pls_pkg::ST_OK;
            end
        endcase
    end

    // Row of cells, each wired to its two neighbors
    for (genvar i = 0; i < pls_pkg::DEPTH; i++)
    begin : g_cell
        logic [pls_pkg::ELEM_BITS-1:0] left_in;
        logic [pls_pkg::ELEM_BITS-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_left
            assign left_in = cell_data[i-1];
        end

        if (i == pls_pkg::DEPTH - 1)
        begin : g_end
            assign right_in = '0;
        end
        else
        begin : g_right
            assign right_in = cell_data[i+1];
        end

        pls_cell u_cell
        (
            .clk        (clk),
            .upd        (accept),
            .ctrl       (ctrl),
            .index      (pls_pkg::IDX_BITS'(i)),
            .new_value  (new_value),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // Collect the selected element over one registered stage
    pls_gather u_gather
    (
        .clk     (clk),
        .load    (accept),
        .cell_rd (cell_rd),
        .word    (gathered)
    );

    // Handshake and control strobes
    always_comb
    begin
        s_tready = (state_reg == pls_pkg::S_IDLE);
        accept   = s_tvalid && s_tready;
        load_out = (state_reg == pls_pkg::S_RESULT) && (!out_valid_reg || m_tready);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pls_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = pls_pkg::S_RESULT;
                end
            end
            pls_pkg::S_RESULT:
            begin
                if (load_out)
                begin
                    state_next = pls_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pls_pkg::S_IDLE;
            end
        endcase
    end

    // Output register contents
    always_comb
    begin
        out_data_next = out_data_reg;
        if (load_out)
        begin
            out_data_next = '0;
            out_data_next[pls_pkg::OUT_ST_LSB +: pls_pkg::STATUS_BITS] = status_reg;
            out_data_next[pls_pkg::OUT_RD_LSB +: pls_pkg::ELEM_BITS]   = gathered;
            out_data_next[pls_pkg::OUT_CNT_LSB +: pls_pkg::CNT_BITS]   = count_reg;
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pls_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== design/pls_checker.sv =====
// ----------------------------------------------------------------------------
// pls_checker
// Port-level checks on the list store's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pls_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [pls_pkg::IN_DATA_BITS-1:0]  s_tdata,
    input  logic [pls_pkg::KIND_BITS-1:0]     s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [pls_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    logic [pls_pkg::STATUS_BITS-1:0] res_status;
    logic [pls_pkg::ELEM_BITS-1:0]   res_value;
    logic [pls_pkg::CNT_BITS-1:0]    res_count;
    logic                            in_xfer;
    logic                            in_unused;

    assign res_status = m_tdata[pls_pkg::OUT_ST_LSB +: pls_pkg::STATUS_BITS];
    assign res_value  = m_tdata[pls_pkg::OUT_RD_LSB +: pls_pkg::ELEM_BITS];
    assign res_count  = m_tdata[pls_pkg::OUT_CNT_LSB +: pls_pkg::CNT_BITS];
    assign in_xfer    = s_tvalid && s_tready;
    assign in_unused  = ^{s_tdata, s_tuser};

    // Stalled result holds
    `CHK_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // One operation in flight: no accept right after an accept
    `CHK_NEXT(a_one_in_flight, clk, rst_n, in_xfer && (in_unused || !in_unused), !s_tready)

    // Count never exceeds capacity
    `CHK_SAME(a_count_range, clk, rst_n, m_tvalid,
              res_count <= pls_pkg::CNT_BITS'(pls_pkg::DEPTH))

    // A failed operation returns no element
    `CHK_SAME(a_fail_zero, clk, rst_n, m_tvalid && (res_status != pls_pkg::ST_OK),
              res_value == '0)

    // Full status only with a full list
    `CHK_SAME(a_full_count, clk, rst_n, m_tvalid && (res_status == pls_pkg::ST_FULL),
              res_count == pls_pkg::CNT_BITS'(pls_pkg::DEPTH))

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);
